@@ rtl/core/nfd_pkg.sv @@
//------------------------------------------------------------------------------
// Notify frame decoder package
// Shared types, status and kind codes, and sizes for the frame decoder.
//------------------------------------------------------------------------------
`default_nettype none

package nfd_pkg;

    localparam int unsigned MAX_TEXT = 64;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;
    localparam logic [1:0] ST_LONG    = 2'd3;

    localparam logic [1:0] KIND_NOTIFY = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_PING   = 2'd2;
    localparam logic [1:0] KIND_PONG   = 2'd3;

    localparam logic [1:0] REG_TAG_NOTIFY = 2'd0;
    localparam logic [1:0] REG_TAG_ACK    = 2'd1;
    localparam logic [1:0] REG_TAG_PING   = 2'd2;
    localparam logic [1:0] REG_TAG_PONG   = 2'd3;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_buffer;
    } in_beat_t;

    typedef struct packed {
        logic       record_type;
        logic [1:0] status;
        logic [1:0] frame_kind;
        logic [7:0] agent_id;
        logic [7:0] agent_status;
        logic [6:0] text_length;
        logic [7:0] text_byte;
        logic [5:0] text_position;
        logic       final_record;
    } out_beat_t;

    typedef struct packed {
        logic       has_text;
        logic [7:0] text_byte;
        logic [5:0] text_position;
        logic       has_summary;
        logic [1:0] status;
        logic [1:0] frame_kind;
        logic [7:0] agent_id;
        logic [7:0] agent_status;
        logic [6:0] text_length;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/nfd_front.sv @@
//------------------------------------------------------------------------------
// Notify frame decoder front end
// Holds the tag registers, parses one byte per beat and issues one command
// per byte that yields any record.
//------------------------------------------------------------------------------
`default_nettype none

module nfd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire nfd_pkg::in_beat_t in_data,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             queue_full,
    output logic                  push,
    output nfd_pkg::cmd_t         push_cmd
);

    localparam logic [2:0] PH_TAG   = 3'd0;
    localparam logic [2:0] PH_AGENT = 3'd1;
    localparam logic [2:0] PH_STATE = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_TEXT  = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    logic [7:0] tag_notify_reg, tag_ack_reg, tag_ping_reg, tag_pong_reg;
    logic [2:0] phase_reg, phase_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] agent_reg, agent_next;
    logic [7:0] agent_status_reg, agent_status_next;
    logic [6:0] text_length_reg, text_length_next;
    logic [6:0] count_reg, count_next;
    logic [1:0] status_reg, status_next;
    logic       accept;
    logic [7:0] b;
    logic [1:0] sum_status;
    nfd_pkg::cmd_t cmd;

    assign in_stall = queue_full;
    assign accept = in_valid && !queue_full;
    assign b = in_data.byte_in;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next = kind_reg;
        agent_next = agent_reg;
        agent_status_next = agent_status_reg;
        text_length_next = text_length_reg;
        count_next = count_reg;
        status_next = status_reg;
        cmd = '0;
        sum_status = nfd_pkg::ST_OK;

        unique case (phase_reg)
            PH_TAG:
            begin
                priority if (b == tag_notify_reg)
                begin
                    kind_next = nfd_pkg::KIND_NOTIFY;
                    phase_next = PH_AGENT;
                end
                else if (b == tag_ack_reg)
                begin
                    kind_next = nfd_pkg::KIND_ACK;
                    phase_next = PH_AGENT;
                end
                else if (b == tag_ping_reg)
                begin
                    kind_next = nfd_pkg::KIND_PING;
                    status_next = nfd_pkg::ST_OK;
                    phase_next = PH_DONE;
                end
                else if (b == tag_pong_reg)
                begin
                    kind_next = nfd_pkg::KIND_PONG;
                    status_next = nfd_pkg::ST_OK;
                    phase_next = PH_DONE;
                end
                else
                begin
                    status_next = nfd_pkg::ST_UNKNOWN;
                    phase_next = PH_DONE;
                end
            end
            PH_AGENT:
            begin
                agent_next = b;
                if (kind_reg == nfd_pkg::KIND_ACK)
                begin
                    status_next = nfd_pkg::ST_OK;
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = PH_STATE;
                end
            end
            PH_STATE:
            begin
                agent_status_next = b;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                if (b > 8'(nfd_pkg::MAX_TEXT))
                begin
                    status_next = nfd_pkg::ST_LONG;
                    phase_next = PH_DONE;
                end
                else
                begin
                    text_length_next = b[6:0];
                    count_next = '0;
                    if (b == 8'd0)
                    begin
                        status_next = nfd_pkg::ST_OK;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_TEXT;
                    end
                end
            end
            PH_TEXT:
            begin
                cmd.has_text = 1'b1;
                cmd.text_byte = b;
                cmd.text_position = count_reg[5:0];
                count_next = count_reg + 7'd1;
                if (count_next >= text_length_reg)
                begin
                    status_next = nfd_pkg::ST_OK;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        if (in_data.end_of_buffer)
        begin
            sum_status = (phase_next == PH_DONE) ? status_next : nfd_pkg::ST_TRUNC;
            cmd.has_summary = 1'b1;
            cmd.status = sum_status;
            if (sum_status == nfd_pkg::ST_OK)
            begin
                cmd.frame_kind = kind_next;
                cmd.agent_id = agent_next;
                cmd.agent_status = agent_status_next;
                cmd.text_length = text_length_next;
            end
            phase_next = PH_TAG;
            kind_next = '0;
            agent_next = '0;
            agent_status_next = '0;
            text_length_next = '0;
            count_next = '0;
            status_next = '0;
        end
    end

    assign push = accept && (cmd.has_text || cmd.has_summary);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_notify_reg <= 8'd1;
            tag_ack_reg <= 8'd2;
            tag_ping_reg <= 8'd3;
            tag_pong_reg <= 8'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nfd_pkg::REG_TAG_NOTIFY: tag_notify_reg <= cfg_data;
                nfd_pkg::REG_TAG_ACK:    tag_ack_reg <= cfg_data;
                nfd_pkg::REG_TAG_PING:   tag_ping_reg <= cfg_data;
                nfd_pkg::REG_TAG_PONG:   tag_pong_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            kind_reg <= '0;
            agent_reg <= '0;
            agent_status_reg <= '0;
            text_length_reg <= '0;
            count_reg <= '0;
            status_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            kind_reg <= kind_next;
            agent_reg <= agent_next;
            agent_status_reg <= agent_status_next;
            text_length_reg <= text_length_next;
            count_reg <= count_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nfd_cmd_queue.sv @@
//------------------------------------------------------------------------------
// Notify frame decoder command queue
// Small register queue that decouples the parser from the record emitter.
//------------------------------------------------------------------------------
`default_nettype none

module nfd_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire nfd_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output nfd_pkg::cmd_t      head_cmd,
    output logic               empty
);

    nfd_pkg::cmd_t slot_reg [nfd_pkg::QUEUE_DEPTH];
    logic [nfd_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [nfd_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full = (count_reg == nfd_pkg::QCNT_W'(nfd_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nfd_back.sv @@
//------------------------------------------------------------------------------
// Notify frame decoder back end
// Turns each queued command into a text record, a summary record or both,
// and holds them in the output register.
//------------------------------------------------------------------------------
`default_nettype none

module nfd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          queue_empty,
    input  wire nfd_pkg::cmd_t head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output nfd_pkg::out_beat_t out_data
);

    logic               out_valid_reg, out_valid_next;
    nfd_pkg::out_beat_t out_reg, out_next;
    logic               sum_pending_reg, sum_pending_next;
    nfd_pkg::cmd_t      held_reg, held_next;
    logic               slot_free;

    function automatic nfd_pkg::out_beat_t summary_beat(input nfd_pkg::cmd_t c);
        nfd_pkg::out_beat_t o;
        o = '0;
        o.record_type = 1'b1;
        o.status = c.status;
        o.frame_kind = c.frame_kind;
        o.agent_id = c.agent_id;
        o.agent_status = c.agent_status;
        o.text_length = c.text_length;
        o.final_record = 1'b1;
        return o;
    endfunction

    function automatic nfd_pkg::out_beat_t text_beat(input nfd_pkg::cmd_t c);
        nfd_pkg::out_beat_t o;
        o = '0;
        o.text_byte = c.text_byte;
        o.text_position = c.text_position;
        return o;
    endfunction

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        sum_pending_next = sum_pending_reg;
        held_next = held_reg;
        pop = 1'b0;
        if (slot_free)
        begin
            priority if (sum_pending_reg)
            begin
                out_valid_next = 1'b1;
                out_next = summary_beat(held_reg);
                sum_pending_next = 1'b0;
            end
            else if (!queue_empty)
            begin
                pop = 1'b1;
                out_valid_next = 1'b1;
                held_next = head_cmd;
                if (head_cmd.has_text)
                begin
                    out_next = text_beat(head_cmd);
                    sum_pending_next = head_cmd.has_summary;
                end
                else
                begin
                    out_next = summary_beat(head_cmd);
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        held_reg <= held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sum_pending_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sum_pending_reg <= sum_pending_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

`default_nettype wire

@@ rtl/core/notify_frame_decoder_top.sv @@
//------------------------------------------------------------------------------
// Notify frame decoder top level
// Parses received buffers byte by byte into text and frame summary records.
//------------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, in_data) takes one buffer byte
// per beat, with end_of_buffer set on the last byte. The output channel
// (out_valid, out_stall, out_data) gives a text record for every text byte of
// a notify frame and one summary record at each buffer end. A byte that ends
// a buffer inside the text gives its text record first, then the summary.
// An input byte is taken every cycle while the four-entry command queue has
// room. Its command is queued for the output register, which sends one
// record per cycle while out_stall is low; a byte yielding two records holds
// it for both. Sustained rate is one byte per cycle when at most one record
// per byte is produced. When the receiver stalls, the output register holds
// its beat and the queue fills; once it is full, in_stall rises. Tag registers
// are written through cfg_we, cfg_index and cfg_data by the user only while
// the block is idle; the block does not enforce this. Reset sets the tag
// registers to 1, 2, 3 and 4, empties the queue and waits for a tag byte.
//------------------------------------------------------------------------------
`default_nettype none

module notify_frame_decoder_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire nfd_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output nfd_pkg::out_beat_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data
);

    logic          push, queue_full, pop, queue_empty;
    nfd_pkg::cmd_t push_cmd, head_cmd;

    nfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    nfd_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty)
    );

    nfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

@@ rtl/core/nfd_checker.sv @@
//------------------------------------------------------------------------------
// Notify frame decoder checker
// Port-level checks on the records leaving the frame decoder.
//------------------------------------------------------------------------------
`default_nettype none

module nfd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire nfd_pkg::out_beat_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled output beat changed.");

    a_text_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.record_type |->
            !out_data.final_record && out_data.status == nfd_pkg::ST_OK
            && out_data.text_length == 7'd0 && out_data.agent_id == 8'd0)
        else $error("Text record carries summary fields.");

    a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.record_type |->
            out_data.final_record && out_data.text_byte == 8'd0
            && out_data.text_position == 6'd0)
        else $error("Summary record malformed.");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.record_type && out_data.status != nfd_pkg::ST_OK |->
            out_data.frame_kind == 2'd0 && out_data.agent_id == 8'd0
            && out_data.agent_status == 8'd0 && out_data.text_length == 7'd0)
        else $error("Error summary carries frame fields.");

endmodule

bind notify_frame_decoder_top nfd_checker u_nfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

@@ verif/nfd_record_checker.sv @@
//------------------------------------------------------------------------------
// Notify frame decoder record checker
// Watches the byte, record and tag register ports of the decoder. It keeps
// its own frame parser, queues the text and summary records that each
// accepted byte should cause, and compares every accepted record with the
// oldest queued one, field by field.
//------------------------------------------------------------------------------

module nfd_record_checker
    import nfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire in_beat_t   in_data,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire out_beat_t  out_data,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output int              mismatches,
    output int              pending,
    output int              text_records,
    output int              summaries
);

    typedef enum logic [2:0] {
        WAIT_TAG,
        GET_AGENT,
        GET_STATE,
        GET_LEN,
        GET_TEXT,
        FRAME_DONE
    } parse_phase_t;

    parse_phase_t phase;
    logic [1:0]   kind;
    logic [7:0]   agent;
    logic [7:0]   agent_state;
    logic [6:0]   declared_len;
    logic [6:0]   text_seen;
    logic [1:0]   frame_status;
    logic [7:0]   tag_value [4];
    out_beat_t    expected_records [$];
    int           errors;
    int           texts_seen;
    int           summaries_seen;

    function automatic void start_over();
        phase = WAIT_TAG;
        kind = '0;
        agent = '0;
        agent_state = '0;
        declared_len = '0;
        text_seen = '0;
        frame_status = ST_OK;
    endfunction

    function automatic void close_frame(input logic [1:0] st);
        frame_status = st;
        phase = FRAME_DONE;
    endfunction

    function automatic void parse_byte(input in_beat_t beat);
        out_beat_t  rec;
        logic [1:0] st;
        case (phase)
            WAIT_TAG:
            begin
                if (beat.byte_in == tag_value[REG_TAG_NOTIFY])
                begin
                    kind = KIND_NOTIFY;
                    phase = GET_AGENT;
                end
                else if (beat.byte_in == tag_value[REG_TAG_ACK])
                begin
                    kind = KIND_ACK;
                    phase = GET_AGENT;
                end
                else if (beat.byte_in == tag_value[REG_TAG_PING])
                begin
                    kind = KIND_PING;
                    close_frame(ST_OK);
                end
                else if (beat.byte_in == tag_value[REG_TAG_PONG])
                begin
                    kind = KIND_PONG;
                    close_frame(ST_OK);
                end
                else
                begin
                    close_frame(ST_UNKNOWN);
                end
            end
            GET_AGENT:
            begin
                agent = beat.byte_in;
                if (kind == KIND_ACK)
                    close_frame(ST_OK);
                else
                    phase = GET_STATE;
            end
            GET_STATE:
            begin
                agent_state = beat.byte_in;
                phase = GET_LEN;
            end
            GET_LEN:
            begin
                if (beat.byte_in > MAX_TEXT)
                begin
                    close_frame(ST_LONG);
                end
                else
                begin
                    declared_len = beat.byte_in[6:0];
                    text_seen = '0;
                    if (beat.byte_in == 8'd0)
                        close_frame(ST_OK);
                    else
                        phase = GET_TEXT;
                end
            end
            GET_TEXT:
            begin
                rec = '0;
                rec.text_byte = beat.byte_in;
                rec.text_position = text_seen[5:0];
                expected_records.push_back(rec);
                text_seen = text_seen + 7'd1;
                if (text_seen >= declared_len)
                    close_frame(ST_OK);
            end
            default:
            begin
            end
        endcase

        if (beat.end_of_buffer)
        begin
            st = (phase == FRAME_DONE) ? frame_status : ST_TRUNC;
            rec = '0;
            rec.record_type = 1'b1;
            rec.status = st;
            if (st == ST_OK)
            begin
                rec.frame_kind = kind;
                rec.agent_id = agent;
                rec.agent_status = agent_state;
                rec.text_length = declared_len;
            end
            rec.final_record = 1'b1;
            expected_records.push_back(rec);
            start_over();
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_record(input out_beat_t want, input out_beat_t got);
        check_field("record_type", want.record_type, got.record_type);
        check_field("status", want.status, got.status);
        check_field("frame_kind", want.frame_kind, got.frame_kind);
        check_field("agent_id", want.agent_id, got.agent_id);
        check_field("agent_status", want.agent_status, got.agent_status);
        check_field("text_length", want.text_length, got.text_length);
        check_field("text_byte", want.text_byte, got.text_byte);
        check_field("text_position", want.text_position, got.text_position);
        check_field("final_record", want.final_record, got.final_record);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_value = '{8'd1, 8'd2, 8'd3, 8'd4};
            start_over();
            expected_records.delete();
            errors = 0;
            texts_seen = 0;
            summaries_seen = 0;
        end
        else
        begin
            if (cfg_we)
                tag_value[cfg_index] = cfg_data;
            if (in_valid && !in_stall)
                parse_byte(in_data);
            if (out_valid && !out_stall)
            begin
                if (out_data.record_type)
                    summaries_seen++;
                else
                    texts_seen++;
                if (expected_records.size() == 0)
                begin
                    $error("record beat with nothing expected: record_type %0d",
                           out_data.record_type);
                    errors++;
                end
                else
                begin
                    check_record(expected_records.pop_front(), out_data);
                end
            end
        end
        mismatches <= errors;
        pending <= expected_records.size();
        text_records <= texts_seen;
        summaries <= summaries_seen;
    end

endmodule

@@ verif/tb_notify_frame_decoder_top.sv @@
//------------------------------------------------------------------------------
// Notify frame decoder testbench
// Feeds the decoder a few directed buffers and then random frames (mostly
// well formed, some cut short, padded, oversized or with unknown tags) under
// several tag register settings, with bursty input and random output stalls.
// A separate checker predicts and compares every record.
//------------------------------------------------------------------------------

module tb_notify_frame_decoder_top;
    import nfd_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_beat_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_beat_t  out_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    int         mismatches;
    int         pending;
    int         text_records;
    int         summaries;

    logic [7:0] tags [4] = '{8'd1, 8'd2, 8'd3, 8'd4};
    logic [7:0] frame_bytes [$];
    int         bytes_sent = 0;
    int         buffers_sent = 0;
    int         settings_used = 1;
    int         burst_left = 0;
    int         stall_run = 0;
    int         idle_cycles = 0;

    always #5 clk = ~clk;

    notify_frame_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nfd_record_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .text_records (text_records),
        .summaries    (summaries)
    );

    always @(posedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run <= stall_run - 1;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    out_stall <= 1'b0;
                    stall_run <= $urandom_range(10, 60);
                end
                1:
                begin
                    out_stall <= 1'b1;
                    stall_run <= $urandom_range(1, 12);
                end
                default:
                begin
                    out_stall <= 1'($urandom_range(0, 1));
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles.", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] value, input logic last);
        int gap;
        in_valid <= 1'b1;
        in_data <= '{byte_in: value, end_of_buffer: last};
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        buffers_sent++;
    endtask

    task automatic wait_idle(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        tags[index] = value;
        @(posedge clk);
    endtask

    task automatic set_tags(input logic [7:0] notify_tag, input logic [7:0] ack_tag,
                            input logic [7:0] ping_tag, input logic [7:0] pong_tag);
        wait_idle(8);
        write_reg(REG_TAG_NOTIFY, notify_tag);
        write_reg(REG_TAG_ACK, ack_tag);
        write_reg(REG_TAG_PING, ping_tag);
        write_reg(REG_TAG_PONG, pong_tag);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_frame();
        int         shape;
        int         damage;
        int         body_len;
        logic [7:0] tag;
        frame_bytes = {};
        shape = $urandom_range(0, 99);
        if (shape < 45)
        begin
            case ($urandom_range(0, 19))
                0:       body_len = $urandom_range(MAX_TEXT + 1, 255);
                1:       body_len = MAX_TEXT;
                2:       body_len = 0;
                3:       body_len = $urandom_range(9, MAX_TEXT - 1);
                default: body_len = $urandom_range(1, 8);
            endcase
            frame_bytes.push_back(tags[REG_TAG_NOTIFY]);
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'(body_len));
            if (body_len <= MAX_TEXT)
                for (int i = 0; i < body_len; i++)
                    frame_bytes.push_back(8'($urandom));
        end
        else if (shape < 60)
        begin
            frame_bytes.push_back(tags[REG_TAG_ACK]);
            frame_bytes.push_back(8'($urandom));
        end
        else if (shape < 70)
        begin
            frame_bytes.push_back(tags[REG_TAG_PING]);
        end
        else if (shape < 80)
        begin
            frame_bytes.push_back(tags[REG_TAG_PONG]);
        end
        else
        begin
            do
                tag = 8'($urandom);
            while (tag == tags[REG_TAG_NOTIFY] || tag == tags[REG_TAG_ACK] ||
                   tag == tags[REG_TAG_PING] || tag == tags[REG_TAG_PONG]);
            frame_bytes.push_back(tag);
        end

        damage = $urandom_range(0, 99);
        if (damage < 12 && frame_bytes.size() > 1)
        begin
            frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
        end
        else if (damage < 26)
        begin
            repeat ($urandom_range(1, 4))
                frame_bytes.push_back(8'($urandom));
        end
        send_frame();
    endtask

    task automatic run_random(input int byte_target);
        while (bytes_sent < byte_target)
            send_random_frame();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        frame_bytes = {tags[REG_TAG_PING]};
        send_frame();
        frame_bytes = {tags[REG_TAG_PONG]};
        send_frame();
        frame_bytes = {tags[REG_TAG_ACK], 8'hFF};
        send_frame();
        frame_bytes = {tags[REG_TAG_NOTIFY], 8'h00, 8'hFF, 8'd0};
        send_frame();
        frame_bytes = {tags[REG_TAG_NOTIFY], 8'hA5, 8'h5A, 8'd1, 8'hFF};
        send_frame();
        frame_bytes = {8'hFF, 8'h12};
        send_frame();
        frame_bytes = {tags[REG_TAG_NOTIFY], 8'h07, 8'h08, 8'd65};
        send_frame();
        frame_bytes = {tags[REG_TAG_NOTIFY], 8'h05, 8'h06, 8'd3, 8'h41};
        send_frame();
        frame_bytes = {tags[REG_TAG_PING], 8'h77};
        send_frame();

        set_tags(8'h00, 8'hFF, 8'h80, 8'h7F);
        run_random(350);
        set_tags(8'hAA, 8'hAA, 8'hAA, 8'hAA);
        run_random(450);
        set_tags(8'h11, 8'h22, 8'h33, 8'h33);
        run_random(550);
        set_tags(8'h40, 8'h41, 8'h41, 8'h41);
        run_random(650);
        set_tags(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(920);

        wait_idle(12);
        $display("Sent %0d bytes in %0d buffers under %0d tag settings.",
                 bytes_sent, buffers_sent, settings_used);
        $display("Checked %0d text records and %0d frame summaries.",
                 text_records, summaries);
        if (mismatches == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/nfd_pkg.sv
rtl/core/nfd_front.sv
rtl/core/nfd_cmd_queue.sv
rtl/core/nfd_back.sv
rtl/core/notify_frame_decoder_top.sv
rtl/core/nfd_checker.sv
verif/nfd_record_checker.sv
verif/tb_notify_frame_decoder_top.sv
